### sv/multi_axis_rotary_position_ids_assert.svh
// assertion macros for the rotary position id block
`ifndef MULTI_AXIS_ROTARY_POSITION_IDS_ASSERT_SVH
`define MULTI_AXIS_ROTARY_POSITION_IDS_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define MRPI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define MRPI_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define MRPI_ASSERT(lbl, prop, msg)
`define MRPI_ASSERT_RST(lbl, prop, msg)
`endif

`endif

### sv/mrpi_pkg.sv
// shared constants and types for the rotary position id block
package mrpi_pkg;

  localparam int PosBits     = 20;
  localparam int GridSideMax = 64;
  localparam int TokBits     = 18;
  localparam int CfgSideBits = 7;
  localparam int CfgIdxBits  = 2;
  localparam int CfgDataBits = 18;

  localparam int SideBits = $clog2(GridSideMax + 1);
  localparam int IdxBits  = $clog2(GridSideMax);
  localparam int RunCap   = GridSideMax * GridSideMax + 1;
  localparam int RunBits  = $clog2(RunCap + 2);

  localparam logic [CfgIdxBits-1:0] CfgImageToken = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgGridRows   = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgGridCols   = 2'd2;

  typedef struct packed {
    logic [PosBits-1:0] pos_time;
    logic [PosBits-1:0] pos_row;
    logic [PosBits-1:0] pos_col;
    logic [PosBits-1:0] next_free_position;
    logic               span_mismatch;
    logic               error_seen;
    logic               seq_end;
  } res_t;

endpackage

### sv/mrpi_if.sv
// stream and configuration channel interfaces for the rotary position id block
interface mrpi_tok_if;
  logic                         valid;
  logic                         ready;
  logic [mrpi_pkg::TokBits-1:0] token_value;
  logic                         final_token;

  modport source (output valid, output token_value, output final_token, input ready);
  modport sink (input valid, input token_value, input final_token, output ready);
endinterface

interface mrpi_res_if;
  logic                         valid;
  logic                         ready;
  logic [mrpi_pkg::PosBits-1:0] pos_time;
  logic [mrpi_pkg::PosBits-1:0] pos_row;
  logic [mrpi_pkg::PosBits-1:0] pos_col;
  logic [mrpi_pkg::PosBits-1:0] next_free_position;
  logic                         span_mismatch;
  logic                         error_seen;
  logic                         seq_end;

  modport source (output valid, output pos_time, output pos_row, output pos_col,
                  output next_free_position, output span_mismatch, output error_seen,
                  output seq_end, input ready);
  modport sink (input valid, input pos_time, input pos_row, input pos_col,
                input next_free_position, input span_mismatch, input error_seen,
                input seq_end, output ready);
endinterface

interface mrpi_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mrpi_pkg::CfgIdxBits-1:0]  index;
  logic [mrpi_pkg::CfgDataBits-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### sv/multi_axis_rotary_position_ids.sv
// top level: three-axis rotary position ids for a text and image token stream
//
//   channel | dir | payload                                   | handshake
//   cfg_i   | in  | index, data                               | valid/ready
//   tok_i   | in  | token_value, final_token                  | valid/ready
//   res_o   | out | pos_time/row/col, next_free_position, flags | valid/ready
//
// one token per cycle sustained while results are taken; an input beat reaches its result beat
// through the input register, then the position update into the result register
// the position counter and run state update together with the result register, which sets the rate
// reset clears run state, input and result valid; config registers return to defaults, no sweep
// a stalled result holds its register; the input stage still drains into it once free
module multi_axis_rotary_position_ids (
  input  logic     clk_i,
  input  logic     rst_ni,
  mrpi_cfg_if.sink cfg_i,
  mrpi_tok_if.sink tok_i,
  mrpi_res_if.source res_o
);

  localparam int P = mrpi_pkg::PosBits;
  localparam int S = mrpi_pkg::SideBits;
  localparam int I = mrpi_pkg::IdxBits;
  localparam int R = mrpi_pkg::RunBits;

  function automatic logic [P-1:0] sat_add(logic [P-1:0] a, logic [P-1:0] b);
    logic [P:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[P] ? {P{1'b1}} : s[P-1:0];
  endfunction

  function automatic logic [S-1:0] clamp_side(logic [mrpi_pkg::CfgSideBits-1:0] v);
    if (v == '0) begin
      return S'(1);
    end else if (32'(v) > mrpi_pkg::GridSideMax) begin
      return S'(mrpi_pkg::GridSideMax);
    end else begin
      return S'(v);
    end
  endfunction

  // configuration registers
  logic [mrpi_pkg::TokBits-1:0]     img_tok_q;
  logic [mrpi_pkg::CfgSideBits-1:0] grid_rows_q;
  logic [mrpi_pkg::CfgSideBits-1:0] grid_cols_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_tok_q   <= '0;
      grid_rows_q <= mrpi_pkg::CfgSideBits'(1);
      grid_cols_q <= mrpi_pkg::CfgSideBits'(1);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        mrpi_pkg::CfgImageToken: img_tok_q   <= cfg_i.data;
        mrpi_pkg::CfgGridRows:   grid_rows_q <= cfg_i.data[mrpi_pkg::CfgSideBits-1:0];
        mrpi_pkg::CfgGridCols:   grid_cols_q <= cfg_i.data[mrpi_pkg::CfgSideBits-1:0];
        default: ;
      endcase
    end
  end

  logic [S-1:0] rows_c, cols_c, side_c;
  logic [R-1:0] expect_c;

  assign rows_c   = clamp_side(grid_rows_q);
  assign cols_c   = clamp_side(grid_cols_q);
  assign side_c   = (rows_c > cols_c) ? rows_c : cols_c;
  assign expect_c = R'(rows_c) * R'(cols_c);

  // input stage
  logic s1_valid_q, s1_img_q, s1_final_q;
  logic s1_adv;
  logic res_valid_q;
  mrpi_pkg::res_t res_q, res_d;

  assign s1_adv      = s1_valid_q && (!res_valid_q || res_o.ready);
  assign tok_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (tok_i.ready) begin
      s1_valid_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_i.valid && tok_i.ready) begin
      s1_img_q   <= (tok_i.token_value == img_tok_q);
      s1_final_q <= tok_i.final_token;
    end
  end

  // sequence state
  logic [P-1:0] counter_q, counter_d, base_q, base_d;
  logic [I-1:0] row_q, row_d, col_q, col_d;
  logic [R-1:0] rl_q, rl_d;
  logic         in_run_q, in_run_d, sticky_q, sticky_d;

  logic [P-1:0] base, pt, pr, pc, nxt, close_pos;
  logic [I-1:0] ri0, ci0, ri, ci;
  logic [S-1:0] ci_inc, ri_inc;
  logic [R-1:0] rl0, rl1;
  logic         mism;

  always_comb begin
    counter_d = counter_q;
    base_d    = base_q;
    row_d     = row_q;
    col_d     = col_q;
    rl_d      = rl_q;
    in_run_d  = in_run_q;
    mism      = 1'b0;
    base      = in_run_q ? base_q : counter_q;
    ri0       = in_run_q ? row_q : '0;
    ci0       = in_run_q ? col_q : '0;
    rl0       = in_run_q ? rl_q : '0;
    // a side shrunk mid-run wraps a stale index
    ci        = (S'(ci0) >= cols_c) ? '0 : ci0;
    ri        = (S'(ri0) >= rows_c) ? '0 : ri0;
    rl1       = (32'(rl0) < mrpi_pkg::RunCap) ? rl0 + R'(1) : rl0;
    ci_inc    = S'(ci) + S'(1);
    ri_inc    = S'(ri) + S'(1);
    close_pos = sat_add(base_q, P'(side_c));
    pt        = counter_q;
    pr        = counter_q;
    pc        = counter_q;
    nxt       = counter_q;
    if (s1_img_q) begin
      pt       = base;
      pr       = sat_add(base, P'(ri));
      pc       = sat_add(base, P'(ci));
      nxt      = sat_add(base, P'(side_c));
      mism     = (rl1 == expect_c + R'(1)) || (s1_final_q && (rl1 < expect_c));
      in_run_d = 1'b1;
      base_d   = base;
      rl_d     = rl1;
      if (ci_inc >= cols_c) begin
        col_d = '0;
        row_d = (ri_inc >= rows_c) ? '0 : I'(ri_inc);
      end else begin
        col_d = I'(ci_inc);
        row_d = ri;
      end
    end else begin
      if (in_run_q) begin
        mism      = rl_q < expect_c;
        pt        = close_pos;
        pr        = close_pos;
        pc        = close_pos;
        in_run_d  = 1'b0;
      end
      counter_d = sat_add(pt, P'(1));
      nxt       = counter_d;
    end
    sticky_d = sticky_q | mism;

    res_d.pos_time           = pt;
    res_d.pos_row            = pr;
    res_d.pos_col            = pc;
    res_d.next_free_position = nxt;
    res_d.span_mismatch      = mism;
    res_d.error_seen         = sticky_d;
    res_d.seq_end            = s1_final_q;

    if (s1_final_q) begin
      counter_d = '0;
      base_d    = '0;
      row_d     = '0;
      col_d     = '0;
      rl_d      = '0;
      in_run_d  = 1'b0;
      sticky_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q   <= '0;
      base_q      <= '0;
      row_q       <= '0;
      col_q       <= '0;
      rl_q        <= '0;
      in_run_q    <= 1'b0;
      sticky_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        counter_q   <= counter_d;
        base_q      <= base_d;
        row_q       <= row_d;
        col_q       <= col_d;
        rl_q        <= rl_d;
        in_run_q    <= in_run_d;
        sticky_q    <= sticky_d;
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid              = res_valid_q;
  assign res_o.pos_time           = res_q.pos_time;
  assign res_o.pos_row            = res_q.pos_row;
  assign res_o.pos_col            = res_q.pos_col;
  assign res_o.next_free_position = res_q.next_free_position;
  assign res_o.span_mismatch      = res_q.span_mismatch;
  assign res_o.error_seen         = res_q.error_seen;
  assign res_o.seq_end            = res_q.seq_end;

`include "multi_axis_rotary_position_ids_assert.svh"

  `MRPI_ASSERT(a_final_clears, (s1_adv && s1_final_q) |=> (counter_q == '0 && !in_run_q && !sticky_q), "state not cleared after final token")
  `MRPI_ASSERT(a_sticky_covers, res_valid_q |-> (!res_q.span_mismatch || res_q.error_seen), "mismatch without sticky error")
  `MRPI_ASSERT(a_axis_order, res_valid_q |-> (res_q.pos_row >= res_q.pos_time && res_q.pos_col >= res_q.pos_time), "row or column below time axis")
  `MRPI_ASSERT_RST(a_reset_idle, !rst_ni |-> !res_valid_q, "result valid during reset")

endmodule

### tb/sv/tb.sv
// testbench for the three-axis rotary position id block: predicted ids checked per result beat
`timescale 1ns / 1ps

module tb;

  localparam longint unsigned PosMax        = (64'd1 << mrpi_pkg::PosBits) - 1;
  localparam int              WatchdogLimit = 2000;
  localparam int              HoldCycles    = 300;
  localparam logic [mrpi_pkg::CfgIdxBits-1:0] CfgSpare = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni;

  mrpi_cfg_if cfg_if ();
  mrpi_tok_if tok_if ();
  mrpi_res_if res_if ();

  multi_axis_rotary_position_ids dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .tok_i  (tok_if),
    .res_o  (res_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // tracks the running position counter and image run state, queues predicted ids
  class position_tracker;
    bit [mrpi_pkg::TokBits-1:0]     image_tok;
    bit [mrpi_pkg::CfgSideBits-1:0] rows_reg;
    bit [mrpi_pkg::CfgSideBits-1:0] cols_reg;
    longint unsigned                counter;
    longint unsigned                base;
    int unsigned                    row_idx;
    int unsigned                    col_idx;
    int unsigned                    run_len;
    bit                             in_run;
    bit                             sticky;
    mrpi_pkg::res_t                 pending_ids[$];
    int unsigned                    errors;

    function new();
      image_tok = '0;
      rows_reg  = mrpi_pkg::CfgSideBits'(1);
      cols_reg  = mrpi_pkg::CfgSideBits'(1);
      errors    = 0;
      clear_run();
    endfunction

    function void clear_run();
      counter = 0;
      base    = 0;
      row_idx = 0;
      col_idx = 0;
      run_len = 0;
      in_run  = 1'b0;
      sticky  = 1'b0;
    endfunction

    function int unsigned side_of(bit [mrpi_pkg::CfgSideBits-1:0] v);
      if (v < 1) return 1;
      if (v > mrpi_pkg::GridSideMax) return mrpi_pkg::GridSideMax;
      return v;
    endfunction

    function longint unsigned sat_pos(longint unsigned a, longint unsigned b);
      return (a + b > PosMax) ? PosMax : a + b;
    endfunction

    function void set_reg(logic [mrpi_pkg::CfgIdxBits-1:0] idx,
                          logic [mrpi_pkg::CfgDataBits-1:0] d);
      case (idx)
        mrpi_pkg::CfgImageToken: image_tok = d[mrpi_pkg::TokBits-1:0];
        mrpi_pkg::CfgGridRows:   rows_reg  = d[mrpi_pkg::CfgSideBits-1:0];
        mrpi_pkg::CfgGridCols:   cols_reg  = d[mrpi_pkg::CfgSideBits-1:0];
        default: ;
      endcase
    endfunction

    function void note_token(bit [mrpi_pkg::TokBits-1:0] tok, bit fin);
      int unsigned    rows, cols, span, side;
      bit             mis;
      mrpi_pkg::res_t ids;
      rows = side_of(rows_reg);
      cols = side_of(cols_reg);
      span = rows * cols;
      side = (rows > cols) ? rows : cols;
      mis  = 1'b0;
      ids  = '0;
      if (tok == image_tok) begin
        if (!in_run) begin
          in_run  = 1'b1;
          base    = counter;
          row_idx = 0;
          col_idx = 0;
          run_len = 0;
        end
        // a grid shrunk mid run wraps indices that fell outside
        if (col_idx >= cols) col_idx = 0;
        if (row_idx >= rows) row_idx = 0;
        ids.pos_time = mrpi_pkg::PosBits'(base);
        ids.pos_row  = mrpi_pkg::PosBits'(sat_pos(base, row_idx));
        ids.pos_col  = mrpi_pkg::PosBits'(sat_pos(base, col_idx));
        if (run_len < mrpi_pkg::RunCap) run_len++;
        if (run_len == span + 1) mis = 1'b1;
        col_idx++;
        if (col_idx >= cols) begin
          col_idx = 0;
          row_idx++;
          if (row_idx >= rows) row_idx = 0;
        end
        ids.next_free_position = mrpi_pkg::PosBits'(sat_pos(base, side));
        if (fin && run_len < span) mis = 1'b1;
      end else begin
        if (in_run) begin
          if (run_len < span) mis = 1'b1;
          counter = sat_pos(base, side);
          in_run  = 1'b0;
        end
        ids.pos_time = mrpi_pkg::PosBits'(counter);
        ids.pos_row  = mrpi_pkg::PosBits'(counter);
        ids.pos_col  = mrpi_pkg::PosBits'(counter);
        counter = sat_pos(counter, 1);
        ids.next_free_position = mrpi_pkg::PosBits'(counter);
      end
      if (mis) sticky = 1'b1;
      ids.span_mismatch = mis;
      ids.error_seen    = sticky;
      ids.seq_end       = fin;
      pending_ids = {pending_ids, ids};
      if (fin) clear_run();
    endfunction

    task flag_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_ids(mrpi_pkg::res_t got);
      mrpi_pkg::res_t want;
      if (pending_ids.size() == 0) begin
        flag_mismatch("result beat with no token pending");
        return;
      end
      want = pending_ids.pop_front();
      if (got.pos_time !== want.pos_time)
        flag_mismatch($sformatf("pos_time %0d, want %0d", got.pos_time, want.pos_time));
      if (got.pos_row !== want.pos_row)
        flag_mismatch($sformatf("pos_row %0d, want %0d", got.pos_row, want.pos_row));
      if (got.pos_col !== want.pos_col)
        flag_mismatch($sformatf("pos_col %0d, want %0d", got.pos_col, want.pos_col));
      if (got.next_free_position !== want.next_free_position)
        flag_mismatch($sformatf("next_free_position %0d, want %0d",
                                got.next_free_position, want.next_free_position));
      if (got.span_mismatch !== want.span_mismatch)
        flag_mismatch($sformatf("span_mismatch %b, want %b",
                                got.span_mismatch, want.span_mismatch));
      if (got.error_seen !== want.error_seen)
        flag_mismatch($sformatf("error_seen %b, want %b", got.error_seen, want.error_seen));
      if (got.seq_end !== want.seq_end)
        flag_mismatch($sformatf("seq_end %b, want %b", got.seq_end, want.seq_end));
    endtask
  endclass

  position_tracker tracker;
  bit              burst;
  bit              hold_go;
  bit              hold_res;
  int unsigned     tokens_sent;

  function automatic int idle_draw();
    return burst ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic bit [mrpi_pkg::TokBits-1:0] text_token();
    bit [mrpi_pkg::TokBits-1:0] t;
    t = mrpi_pkg::TokBits'($urandom_range(0, (1 << mrpi_pkg::TokBits) - 1));
    if (t == tracker.image_tok) t[0] = ~t[0];
    return t;
  endfunction

  // predict on input beats first, so a same-edge result still finds its entry
  always @(posedge clk_i) begin
    if (rst_ni && cfg_if.valid && cfg_if.ready)
      tracker.set_reg(cfg_if.index, cfg_if.data);
    if (rst_ni && tok_if.valid && tok_if.ready)
      tracker.note_token(tok_if.token_value, tok_if.final_token);
    if (rst_ni && res_if.valid && res_if.ready)
      tracker.check_ids(mrpi_pkg::res_t'({res_if.pos_time, res_if.pos_row, res_if.pos_col,
                                          res_if.next_free_position, res_if.span_mismatch,
                                          res_if.error_seen, res_if.seq_end}));
  end

  task automatic send_token(bit [mrpi_pkg::TokBits-1:0] tv, bit fin);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      tok_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    tok_if.valid       = 1'b1;
    tok_if.token_value = tv;
    tok_if.final_token = fin;
    do @(posedge clk_i); while (tok_if.ready !== 1'b1);
    @(negedge clk_i);
    tokens_sent++;
  endtask

  task automatic send_images(int n, bit fin_last);
    for (int i = 0; i < n; i++) send_token(tracker.image_tok, fin_last && (i == n - 1));
  endtask

  task automatic write_reg(logic [mrpi_pkg::CfgIdxBits-1:0] idx,
                           logic [mrpi_pkg::CfgDataBits-1:0] d);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = d;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // upper data bits are don't-care for the grid registers, so keep them random
  task automatic set_grid(bit [mrpi_pkg::CfgSideBits-1:0] r,
                          bit [mrpi_pkg::CfgSideBits-1:0] c);
    bit [mrpi_pkg::CfgDataBits-1:0] d;
    d = mrpi_pkg::CfgDataBits'($urandom);
    d[mrpi_pkg::CfgSideBits-1:0] = r;
    write_reg(mrpi_pkg::CfgGridRows, d);
    d = mrpi_pkg::CfgDataBits'($urandom);
    d[mrpi_pkg::CfgSideBits-1:0] = c;
    write_reg(mrpi_pkg::CfgGridCols, d);
  endtask

  task automatic wait_drained();
    tok_if.valid = 1'b0;
    while (tracker.pending_ids.size() != 0) @(negedge clk_i);
  endtask

  // mostly well-formed image runs between text, some short or long runs, some noise
  task automatic play_sequence();
    bit [mrpi_pkg::TokBits-1:0] seq[$];
    int unsigned                span, len;
    span  = tracker.side_of(tracker.rows_reg) * tracker.side_of(tracker.cols_reg);
    burst = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12))
        seq = {seq, (($urandom_range(0, 2) == 0) ? tracker.image_tok : text_token())};
    end else begin
      repeat ($urandom_range(1, 5)) begin
        repeat ($urandom_range(0, 2)) seq = {seq, text_token()};
        case ($urandom_range(0, 7))
          0:       len = $urandom_range(1, span);
          1:       len = span + $urandom_range(1, 3);
          default: len = span;
        endcase
        repeat (len) seq = {seq, tracker.image_tok};
        if ($urandom_range(0, 3) != 0) seq = {seq, text_token()};
      end
    end
    foreach (seq[i]) send_token(seq[i], i == seq.size() - 1);
    burst = 1'b0;
  endtask

  initial begin : hold_off
    hold_res = 1'b0;
    wait (hold_go);
    hold_res = 1'b1;
    repeat (HoldCycles) @(negedge clk_i);
    hold_res = 1'b0;
  end

  initial begin : result_sink
    int gap;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = idle_draw();
      if (gap > 0 || hold_res) begin
        res_if.ready = 1'b0;
        repeat (gap) @(negedge clk_i);
        while (hold_res) @(negedge clk_i);
      end
      res_if.ready = 1'b1;
      do @(posedge clk_i); while (res_if.valid !== 1'b1);
      @(negedge clk_i);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((tok_if.valid && tok_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int unsigned                    target;
    int                             p;
    bit [mrpi_pkg::TokBits-1:0]     img;
    bit [mrpi_pkg::CfgSideBits-1:0] r, c;
    rst_ni             = 1'b0;
    tok_if.valid       = 1'b0;
    tok_if.token_value = '0;
    tok_if.final_token = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = mrpi_pkg::CfgImageToken;
    cfg_if.data        = '0;
    burst              = 1'b0;
    hold_go            = 1'b0;
    tokens_sent        = 0;
    tracker            = new();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset defaults: image id 0 on a 1x1 grid, second image overruns the run
    send_token({mrpi_pkg::TokBits{1'b1}}, 1'b0);
    send_images(2, 1'b0);
    send_token(18'd5, 1'b0);
    send_images(1, 1'b1);
    wait_drained();

    write_reg(CfgSpare, mrpi_pkg::CfgDataBits'($urandom));
    write_reg(mrpi_pkg::CfgImageToken, {mrpi_pkg::TokBits{1'b1}});
    set_grid(7'd3, 7'd2);
    // exact run, short run closed by text, short run closed by a final image
    send_token('0, 1'b0);
    send_images(6, 1'b0);
    send_token(text_token(), 1'b0);
    send_images(2, 1'b0);
    send_token(text_token(), 1'b0);
    send_images(3, 1'b1);
    wait_drained();

    // grid shrinks in the middle of a run
    set_grid(7'd4, 7'd4);
    send_images(5, 1'b0);
    wait_drained();
    set_grid(7'd1, 7'd2);
    send_images(2, 1'b0);
    send_token(text_token(), 1'b1);
    wait_drained();

    // largest grid, short run across a few rows
    set_grid(7'd64, 7'd64);
    burst = 1'b1;
    send_images(mrpi_pkg::GridSideMax * 2 + 5, 1'b0);
    send_token(text_token(), 1'b0);
    send_token(text_token(), 1'b1);
    wait_drained();

    // out of range sides clamp to 64x1
    write_reg(mrpi_pkg::CfgImageToken, mrpi_pkg::CfgDataBits'($urandom));
    set_grid(7'd127, 7'd0);
    send_images(mrpi_pkg::GridSideMax, 1'b0);
    send_token(text_token(), 1'b0);
    send_images(3, 1'b0);
    send_token(text_token(), 1'b0);
    send_token(text_token(), 1'b1);
    burst = 1'b0;

    for (p = 0; p < 7; p++) begin
      wait_drained();
      case (p)
        1:       img = '0;
        2:       img = {mrpi_pkg::TokBits{1'b1}};
        default: img = mrpi_pkg::TokBits'($urandom_range(0, (1 << mrpi_pkg::TokBits) - 1));
      endcase
      case (p)
        3:       begin r = 7'd0;  c = 7'd5;  end
        5:       begin r = 7'd8;  c = 7'd8;  end
        6:       begin r = 7'd1;  c = 7'd64; end
        default: begin
          r = mrpi_pkg::CfgSideBits'($urandom_range(1, 6));
          c = mrpi_pkg::CfgSideBits'($urandom_range(1, 6));
        end
      endcase
      write_reg(mrpi_pkg::CfgImageToken, img);
      set_grid(r, c);
      if (p == 0) hold_go = 1'b1;
      target = tokens_sent + 180;
      while (tokens_sent < target) play_sequence();
    end

    wait_drained();
    repeat (10) @(negedge clk_i);
    if (tracker.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
